### src/brf_pkg.sv
// ---------------------------------------------------------------------------
// brf_pkg: shared definitions for the byte ring FIFO with rollback
// Command codes and the per-item result flag bundle.
// ---------------------------------------------------------------------------
package brf_pkg;

  localparam int CMD_W = 2;
  localparam int BYTE_W = 8;

  localparam logic [CMD_W-1:0] CMD_WRITE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MARK     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ROLLBACK = 2'd3;

  // flags carried alongside a result through the pipe
  typedef struct packed {
    logic read_valid;
    logic write_accepted;
    logic rollback_clamped;
  } brf_flags_t;

endpackage

### src/brf_ram.sv
// ---------------------------------------------------------------------------
// brf_ram: single-port byte store
// One access per cycle, write or read; read data registered.
// ---------------------------------------------------------------------------
module brf_ram
  import brf_pkg::*;
#(
  parameter int AW = 12
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [AW-1:0]     addr,
  input  logic [BYTE_W-1:0] wdata,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### src/byte_ring_fifo_with_rollback.sv
// ---------------------------------------------------------------------------
// byte_ring_fifo_with_rollback: byte ring buffer with a rollback mark
// Commands write, read, set mark and roll back; one result item per command.
// ---------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                         | tuser
//  ---------+-----+--------------------------------------------+-------------
//  s_axis   | in  | write_data                                 | cmd
//  m_axis   | out | read_data, write_accepted, unread_count,   | read_valid
//           |     | rollback_clamped, zero fill                |
//
//  Flow: one item accepted per cycle while s_axis_tready is high; its result
//  passes the registered read of the byte store (the pipe stage) and then the
//  output register. Pointer and count live in registers updated on accept,
//  so back-to-back commands see each other's effect without interlock.
//  Stalls: s_axis_tready drops only when the pipe stage and the output
//  register are both full and m_axis_tready is low.
//  Reset clears pointers, count and valid bits; the byte store is not
//  cleared and needs no clearing pass.
//
module byte_ring_fifo_with_rollback
  import brf_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  logic clk,
  input  logic rst,

  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [BYTE_W-1:0]                       s_axis_tdata,  // write_data
  input  logic [CMD_W-1:0]                        s_axis_tuser,  // cmd

  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // read_data, write_accepted, unread_count, rollback_clamped, zero fill
  output logic [(((BYTE_W + $clog2(DEPTH) + 3) + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic [0:0]                              m_axis_tuser   // read_valid
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam int OW = BYTE_W + 1 + CW + 1;
  localparam int TW = ((OW + 7) / 8) * 8;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // architectural state
  logic [AW-1:0] read_pointer;
  logic [CW-1:0] unread_total;
  logic [AW-1:0] mark_pointer;
  logic [AW-1:0] read_pointer_next;
  logic [CW-1:0] unread_total_next;
  logic [AW-1:0] mark_pointer_next;

  // pipe stage waiting on RAM read data
  logic          p1_valid;
  brf_flags_t    p1_flags;
  logic [CW-1:0] p1_count;
  logic          p1_move;

  // output register
  logic          out_valid;
  logic [TW-1:0] out_tdata;
  logic          out_tuser;

  logic              accept;
  logic [CMD_W-1:0]  cmd;
  brf_flags_t        flags;
  logic              ram_en;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [AW-1:0]     wpos;
  logic [AW-1:0]     passed;
  logic [CW:0]       restored;
  logic              clamp;
  logic [BYTE_W-1:0] rd_byte;

  assign cmd = s_axis_tuser;

  // output reg frees up when empty or being taken; pipe moves into it
  assign p1_move       = p1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !p1_valid || p1_move;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign wpos     = read_pointer + unread_total[AW-1:0];
  assign passed   = read_pointer - mark_pointer;
  assign restored = {1'b0, unread_total} + {2'b00, passed};
  assign clamp    = restored > {1'b0, DEPTH_C};

  // command decode and next state
  always_comb begin
    read_pointer_next = read_pointer;
    unread_total_next = unread_total;
    mark_pointer_next = mark_pointer;
    flags             = '0;
    ram_en            = 1'b0;
    ram_we            = 1'b0;
    ram_addr          = read_pointer;
    case (cmd)
      CMD_WRITE: begin
        if (unread_total < DEPTH_C) begin
          ram_en               = accept;
          ram_we               = 1'b1;
          ram_addr             = wpos;
          unread_total_next    = unread_total + 1'b1;
          flags.write_accepted = 1'b1;
        end
      end
      CMD_READ: begin
        if (unread_total != '0) begin
          ram_en            = accept;
          read_pointer_next = read_pointer + 1'b1;
          unread_total_next = unread_total - 1'b1;
          flags.read_valid  = 1'b1;
        end
      end
      CMD_MARK: begin
        mark_pointer_next = read_pointer;
      end
      CMD_ROLLBACK: begin
        read_pointer_next      = mark_pointer;
        unread_total_next      = clamp ? DEPTH_C : restored[CW-1:0];
        flags.rollback_clamped = clamp;
      end
      default: begin
      end
    endcase
  end

  brf_ram #(
    .AW(AW)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (s_axis_tdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer <= '0;
      unread_total <= '0;
      mark_pointer <= '0;
    end else if (accept) begin
      read_pointer <= read_pointer_next;
      unread_total <= unread_total_next;
      mark_pointer <= mark_pointer_next;
    end
  end

  // stage 1: RAM data lands here; it holds while stalled since no new access
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      p1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_flags <= flags;
      p1_count <= unread_total_next;
    end
  end

  // non-read results report a zero data byte
  assign rd_byte = p1_flags.read_valid ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      out_tdata <= TW'({p1_flags.rollback_clamped, p1_count,
                        p1_flags.write_accepted, rd_byte});
      out_tuser <= p1_flags.read_valid;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_tdata;
  assign m_axis_tuser  = out_tuser;

`ifndef SYNTHESIS
  // count can never pass the depth, clamp or not
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    unread_total <= DEPTH_C)
    else $error("unread count above depth");

  // a read of a non-empty buffer must reach the pipe stage as a valid byte
  a_read_flows: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_READ && unread_total != '0 |=> p1_valid && p1_flags.read_valid)
    else $error("read result lost");

  // a clamped rollback leaves the buffer full and the pointer at the mark
  a_clamp_full: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_ROLLBACK && clamp |=>
      unread_total == DEPTH_C && read_pointer == $past(mark_pointer))
    else $error("clamped rollback state wrong");

  // the pipe stage never advances into an occupied, stalled output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |=> $stable(out_tdata))
    else $error("output overwritten under stall");
`endif

endmodule
